@@ sv/assert_macros.svh @@
// Assertion shorthands for the plotter move parser.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed: same-cycle implication");

// Next-cycle implication, checked while reset is released.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed: next-cycle implication");

`endif

@@ sv/pmcp_pkg.sv @@
// Shared constants and types for the plotter move command parser.
// No dependencies.
`default_nettype none

package pmcp_pkg;

	localparam int VALUE_WIDTH_DEF = 17;
	localparam int CHAR_W = 8;
	localparam int SPM_W = 10;
	localparam int TASK_W = 2;
	localparam int STEP_W = 27;
	localparam int COUNT_W = 26;
	localparam int STEP_LIMIT = 67107840;

	localparam logic [SPM_W-1:0] SPM_RESET = 10'd80;

	// work item codes
	localparam logic [TASK_W-1:0] CMD_NONE = 2'd0;
	localparam logic [TASK_W-1:0] CMD_MOVE = 2'd1;
	localparam logic [TASK_W-1:0] CMD_PEN_UP = 2'd2;
	localparam logic [TASK_W-1:0] CMD_PEN_DOWN = 2'd3;

	// sub-token letter codes
	localparam logic [2:0] LET_OTHER = 3'd0;
	localparam logic [2:0] LET_X = 3'd1;
	localparam logic [2:0] LET_Y = 3'd2;
	localparam logic [2:0] LET_U = 3'd3;
	localparam logic [2:0] LET_D = 3'd4;

	// value parse phase
	localparam logic [1:0] PH_SIGN = 2'd0;
	localparam logic [1:0] PH_DIGIT = 2'd1;
	localparam logic [1:0] PH_DONE = 2'd2;

	// characters
	localparam logic [CHAR_W-1:0] CH_PIPE = 8'h7C;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_X = 8'h58;
	localparam logic [CHAR_W-1:0] CH_Y = 8'h59;
	localparam logic [CHAR_W-1:0] CH_U = 8'h55;
	localparam logic [CHAR_W-1:0] CH_D = 8'h44;
	localparam logic [CHAR_W-1:0] CH_A_UP = 8'h41;
	localparam logic [CHAR_W-1:0] CH_A_LO = 8'h61;
	localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_0 = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9 = 8'h39;

	// control of a finished token travelling parser -> scaler
	typedef struct packed {
		logic valid;
		logic [TASK_W-1:0] task_res;
		logic end_of_path;
	} emit_ctl_t;

endpackage

`default_nettype wire

@@ sv/pmcp_in_if.sv @@
// Character input channel of the plotter move parser.
// Depends on pmcp_pkg.
`default_nettype none

interface pmcp_in_if import pmcp_pkg::*; ();
	logic valid;
	logic ready;
	logic [CHAR_W-1:0] char_code;
	logic end_of_string;

	modport source (output valid, output char_code, output end_of_string, input ready);
	modport sink (input valid, input char_code, input end_of_string, output ready);
endinterface

`default_nettype wire

@@ sv/pmcp_out_if.sv @@
// Work item output channel of the plotter move parser.
// Depends on pmcp_pkg.
`default_nettype none

interface pmcp_out_if import pmcp_pkg::*; ();
	logic valid;
	logic ready;
	logic [TASK_W-1:0] task_res;
	logic [STEP_W-1:0] x_steps;
	logic [STEP_W-1:0] y_steps;
	logic [COUNT_W-1:0] step_count;
	logic end_of_path;

	modport source (output valid, output task_res, output x_steps, output y_steps,
		output step_count, output end_of_path, input ready);
	modport sink (input valid, input task_res, input x_steps, input y_steps,
		input step_count, input end_of_path, output ready);
endinterface

`default_nettype wire

@@ sv/pmcp_cfg_if.sv @@
// Configuration write channel (steps per mm) of the plotter move parser.
// Depends on pmcp_pkg.
`default_nettype none

interface pmcp_cfg_if import pmcp_pkg::*; ();
	logic valid;
	logic ready;
	logic [SPM_W-1:0] steps_per_mm;

	modport source (output valid, output steps_per_mm, input ready);
	modport sink (input valid, input steps_per_mm, output ready);
endinterface

`default_nettype wire

@@ sv/pmcp_parser.sv @@
// Character parser: token/sub-token state and the stage-1 token register.
// Depends on pmcp_pkg and pmcp_in_if.
`default_nettype none

module pmcp_parser import pmcp_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	pmcp_in_if.sink cmd,
	input wire logic emit_ready,
	output emit_ctl_t emit_ctl,
	output logic [VALUE_WIDTH-1:0] emit_x,
	output logic [VALUE_WIDTH-1:0] emit_y
);

	localparam int MAG_W = VALUE_WIDTH - 1;
	localparam logic [MAG_W-1:0] MAG_MAX = '1;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] xd;
		logic [VALUE_WIDTH-1:0] yd;
		logic [TASK_W-1:0] task_res;
	} dist_t;

	function automatic dist_t commit_f(input logic [2:0] let_code,
		input logic [MAG_W-1:0] mag, input logic neg, input dist_t cur);
		dist_t r;
		logic [VALUE_WIDTH-1:0] v;
		r = cur;
		v = {1'b0, mag};
		if (neg) begin
			v = -v;
		end
		case (let_code)
			LET_X: begin
				r.xd = v;
				r.task_res = CMD_MOVE;
			end
			LET_Y: begin
				r.yd = v;
				r.task_res = CMD_MOVE;
			end
			LET_U: r.task_res = CMD_PEN_UP;
			LET_D: r.task_res = CMD_PEN_DOWN;
			default: r = cur;
		endcase
		return r;
	endfunction

	// parse state
	logic [2:0] letter_q, letter_n;
	logic [MAG_W-1:0] accum_q, accum_n;
	logic neg_q, neg_n;
	logic [1:0] phase_q, phase_n;
	logic expect_q, expect_n;
	dist_t dist_q, dist_n;
	logic skip_q, skip_n;
	logic path_start_q, path_start_n;
	logic token_start_q, token_start_n;

	// stage 1
	logic v_s1;
	logic [TASK_W-1:0] task_s1;
	logic end_s1;
	logic [VALUE_WIDTH-1:0] x_s1, y_s1;

	logic accept;
	logic emit;
	logic e_end;
	dist_t e_dist;
	logic [CHAR_W-1:0] c;
	logic is_ws, is_digit;
	logic [MAG_W+3:0] mul10;

	assign cmd.ready = !v_s1 || emit_ready;
	assign accept = cmd.valid && cmd.ready;
	assign c = cmd.char_code;
	assign is_ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	assign is_digit = (c >= CH_0) && (c <= CH_9);
	assign mul10 = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1)
		+ {{MAG_W{1'b0}}, c[3:0]};

	always_comb begin
		letter_n = letter_q;
		accum_n = accum_q;
		neg_n = neg_q;
		phase_n = phase_q;
		expect_n = expect_q;
		dist_n = dist_q;
		skip_n = skip_q;
		path_start_n = path_start_q;
		token_start_n = token_start_q;
		emit = 1'b0;
		e_end = 1'b0;
		e_dist = '0;

		if (!skip_q && !(path_start_q && is_ws)) begin
			path_start_n = 1'b0;
			if (c == CH_PIPE) begin
				emit = 1'b1;
				e_end = cmd.end_of_string;
				e_dist = commit_f(letter_q, accum_q, neg_q, dist_q);
				dist_n = '0;
				letter_n = LET_OTHER;
				accum_n = '0;
				neg_n = 1'b0;
				phase_n = PH_SIGN;
				expect_n = 1'b1;
				token_start_n = 1'b1;
			end else if (expect_q) begin
				if (token_start_q && (c == CH_A_UP || c == CH_A_LO)) begin
					skip_n = 1'b1;
				end else begin
					case (c)
						CH_X: letter_n = LET_X;
						CH_Y: letter_n = LET_Y;
						CH_U: letter_n = LET_U;
						CH_D: letter_n = LET_D;
						default: letter_n = LET_OTHER;
					endcase
					expect_n = 1'b0;
				end
				token_start_n = 1'b0;
			end else if (c == CH_SPACE) begin
				dist_n = commit_f(letter_q, accum_q, neg_q, dist_q);
				letter_n = LET_OTHER;
				accum_n = '0;
				neg_n = 1'b0;
				phase_n = PH_SIGN;
				expect_n = 1'b1;
			end else if (phase_q == PH_SIGN && is_ws) begin
				phase_n = PH_SIGN;
			end else if (phase_q == PH_SIGN && c == CH_PLUS) begin
				phase_n = PH_DIGIT;
			end else if (phase_q == PH_SIGN && c == CH_MINUS) begin
				neg_n = 1'b1;
				phase_n = PH_DIGIT;
			end else if (phase_q != PH_DONE && is_digit) begin
				accum_n = (mul10 > {4'b0, MAG_MAX}) ? MAG_MAX : mul10[MAG_W-1:0];
				phase_n = PH_DIGIT;
			end else begin
				phase_n = PH_DONE;
			end
		end

		if (cmd.end_of_string) begin
			if (!emit) begin
				emit = 1'b1;
				e_end = 1'b1;
				if (skip_n) begin
					e_dist = '0;
				end else begin
					e_dist = commit_f(letter_n, accum_n, neg_n, dist_n);
				end
			end
			// whole path done: back to reset state
			dist_n = '0;
			letter_n = LET_OTHER;
			accum_n = '0;
			neg_n = 1'b0;
			phase_n = PH_SIGN;
			expect_n = 1'b1;
			token_start_n = 1'b1;
			skip_n = 1'b0;
			path_start_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letter_q <= LET_OTHER;
			accum_q <= '0;
			neg_q <= 1'b0;
			phase_q <= PH_SIGN;
			expect_q <= 1'b1;
			dist_q <= '0;
			skip_q <= 1'b0;
			path_start_q <= 1'b1;
			token_start_q <= 1'b1;
		end else if (accept) begin
			letter_q <= letter_n;
			accum_q <= accum_n;
			neg_q <= neg_n;
			phase_q <= phase_n;
			expect_q <= expect_n;
			dist_q <= dist_n;
			skip_q <= skip_n;
			path_start_q <= path_start_n;
			token_start_q <= token_start_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd.ready) begin
			v_s1 <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			task_s1 <= e_dist.task_res;
			end_s1 <= e_end;
			x_s1 <= e_dist.xd;
			y_s1 <= e_dist.yd;
		end
	end

	assign emit_ctl.valid = v_s1;
	assign emit_ctl.task_res = task_s1;
	assign emit_ctl.end_of_path = end_s1;
	assign emit_x = x_s1;
	assign emit_y = y_s1;

endmodule

`default_nettype wire

@@ sv/pmcp_scale.sv @@
// Scaler: multiply by steps per mm with saturation, then abs/max step count.
// Depends on pmcp_pkg and pmcp_out_if.
`default_nettype none

module pmcp_scale import pmcp_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [SPM_W-1:0] steps_per_mm,
	input wire emit_ctl_t emit_ctl,
	input wire logic [VALUE_WIDTH-1:0] emit_x,
	input wire logic [VALUE_WIDTH-1:0] emit_y,
	output logic emit_ready,
	pmcp_out_if.source res
);

	localparam int PW = VALUE_WIDTH + SPM_W + 1;
	localparam int CW = (PW > STEP_W + 1) ? PW : STEP_W + 1;
	localparam logic signed [CW-1:0] LIM_P = CW'(STEP_LIMIT);
	localparam logic signed [CW-1:0] LIM_N = -LIM_P;

	logic signed [PW-1:0] spm_ext, px, py;
	logic signed [CW-1:0] cx, cy;
	logic [STEP_W-1:0] sx, sy;

	logic v_s2;
	logic [TASK_W-1:0] task_s2;
	logic end_s2;
	logic [STEP_W-1:0] x_s2, y_s2;
	logic [STEP_W-1:0] ax, ay;
	logic s3_ready;

	assign spm_ext = $signed({{(PW-SPM_W){1'b0}}, steps_per_mm});
	assign px = $signed({{(PW-VALUE_WIDTH){emit_x[VALUE_WIDTH-1]}}, emit_x}) * spm_ext;
	assign py = $signed({{(PW-VALUE_WIDTH){emit_y[VALUE_WIDTH-1]}}, emit_y}) * spm_ext;
	assign cx = CW'(px);
	assign cy = CW'(py);

	always_comb begin
		sx = cx[STEP_W-1:0];
		if (cx > LIM_P) begin
			sx = LIM_P[STEP_W-1:0];
		end else if (cx < LIM_N) begin
			sx = LIM_N[STEP_W-1:0];
		end
		sy = cy[STEP_W-1:0];
		if (cy > LIM_P) begin
			sy = LIM_P[STEP_W-1:0];
		end else if (cy < LIM_N) begin
			sy = LIM_N[STEP_W-1:0];
		end
	end

	assign s3_ready = !res.valid || res.ready;
	assign emit_ready = !v_s2 || s3_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (emit_ready) begin
			v_s2 <= emit_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ready && emit_ctl.valid) begin
			task_s2 <= emit_ctl.task_res;
			end_s2 <= emit_ctl.end_of_path;
			x_s2 <= sx;
			y_s2 <= sy;
		end
	end

	assign ax = x_s2[STEP_W-1] ? -x_s2 : x_s2;
	assign ay = y_s2[STEP_W-1] ? -y_s2 : y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (s3_ready) begin
			res.valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_ready && v_s2) begin
			res.task_res <= task_s2;
			res.end_of_path <= end_s2;
			res.x_steps <= x_s2;
			res.y_steps <= y_s2;
			res.step_count <= (ax > ay) ? ax[COUNT_W-1:0] : ay[COUNT_W-1:0];
		end
	end

endmodule

`default_nettype wire

@@ sv/plotter_move_command_parser.sv @@
// Plotter move command parser top level; uses pmcp_pkg, the channel
// interfaces, pmcp_parser and pmcp_scale.
// A word that finishes a token (or ends the path) has its work item registered in
// stage 1 (parse), then stage 2 (scale), then the output register (count).
// Throughput: one character word per cycle; a stage stalls only when full.
// Reset (arst_n low, async): parse state to path start, pipeline empty, steps_per_mm 80.
`default_nettype none

`include "assert_macros.svh"

module plotter_move_command_parser import pmcp_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	pmcp_in_if.sink cmd,
	pmcp_out_if.source res,
	pmcp_cfg_if.sink cfg
);

	// steps per mm; the user writes it only while the block is idle, not enforced here
	logic [SPM_W-1:0] spm_q;

	emit_ctl_t emit_ctl;
	logic [VALUE_WIDTH-1:0] emit_x, emit_y;
	logic emit_ready;

	// shorthand terms for the checks below
	logic eos_take;
	logic move_zero;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spm_q <= SPM_RESET;
		end else if (cfg.valid) begin
			spm_q <= cfg.steps_per_mm;
		end
	end

	// Stage 1: per-character parse. Tokens split on '|', sub-tokens on
	// spaces; a token's distances and task are registered when it finishes.
	pmcp_parser #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.emit_ready(emit_ready),
		.emit_ctl(emit_ctl),
		.emit_x(emit_x),
		.emit_y(emit_y)
	);

	// Stages 2 and 3: scale to motor steps (saturating), then the step
	// count max(|x|,|y|) into the output register.
	pmcp_scale #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.steps_per_mm(spm_q),
		.emit_ctl(emit_ctl),
		.emit_x(emit_x),
		.emit_y(emit_y),
		.emit_ready(emit_ready),
		.res(res)
	);

	assign eos_take = cmd.valid && cmd.ready && cmd.end_of_string;
	assign move_zero = res.x_steps == '0 && res.y_steps == '0 && res.step_count == '0;

	// end of string always produces a token with the end marker next cycle
	`ASSERT_NEXT(a_eos_emits, clk, arst_n, eos_take, emit_ctl.valid && emit_ctl.end_of_path)
	// a token without task letters carries no move
	`ASSERT_IMPLIES(a_none_zero, clk, arst_n, res.valid && res.task_res == CMD_NONE, move_zero)
	// step count never exceeds the saturation bound
	`ASSERT_IMPLIES(a_count_limit, clk, arst_n, res.valid, res.step_count <= COUNT_W'(STEP_LIMIT))

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for plotter_move_command_parser: feeds character words,
// predicts each work item in-bench and checks it field by field on the output.
// Depends on pmcp_pkg, pmcp_in_if, pmcp_out_if, pmcp_cfg_if and the block itself.

module tb;
	import pmcp_pkg::*;

	// lowercase x: not a move letter, must land as an unknown sub-token
	localparam logic [CHAR_W-1:0] CH_X_LO = 8'h78;
	localparam int VALUE_CAP = (1 << (VALUE_WIDTH_DEF - 1)) - 1;
	localparam int PHASES = 6;
	localparam int PHASE_WORDS = 270;
	// three-stage pipe; settle after draining before touching the register
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic end_of_string;
	} char_word_t;

	typedef struct packed {
		logic [TASK_W-1:0] task_res;
		logic [STEP_W-1:0] x_steps;
		logic [STEP_W-1:0] y_steps;
		logic [COUNT_W-1:0] step_count;
		logic end_of_path;
	} work_item_t;

	logic clk = 1'b0;
	logic arst_n;

	always #6 clk = ~clk;

	pmcp_in_if cmd ();
	pmcp_out_if res ();
	pmcp_cfg_if cfg ();

	plotter_move_command_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.res(res),
		.cfg(cfg)
	);

	// words waiting to be driven, and work items the parser owes us
	char_word_t char_backlog[$];
	work_item_t work_due[$];
	int words_queued;
	int mismatches;

	// idle shaping, set per phase by the stimulus block
	int gap_pct;
	int stall_pct;
	bit calm;
	int gap_left;
	int stall_left;

	// ---------------------------------------------------------------
	// Parser mirror: a copy of the register plus the token/sub-token
	// state, advanced once per accepted character word.
	// ---------------------------------------------------------------
	logic [SPM_W-1:0] steps_per_mm_cfg;
	logic [2:0] letter_now;
	int unsigned mag;
	bit minus;
	bit at_letter;
	longint dx_mm;
	longint dy_mm;
	logic [TASK_W-1:0] job;
	bit arc_skip;
	logic [1:0] num_phase;
	bit path_fresh;
	bit token_fresh;

	function automatic bit is_blank(logic [CHAR_W-1:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	task automatic open_sub();
		letter_now = LET_OTHER;
		mag = 0;
		minus = 1'b0;
		num_phase = PH_SIGN;
		at_letter = 1'b1;
	endtask

	task automatic reset_token();
		dx_mm = 0;
		dy_mm = 0;
		job = CMD_NONE;
		open_sub();
		token_fresh = 1'b1;
	endtask

	task automatic reset_path();
		reset_token();
		arc_skip = 1'b0;
		path_fresh = 1'b1;
	endtask

	// fold the finished sub-token into the token; later task letter wins
	task automatic close_sub();
		longint v;
		v = minus ? -longint'(mag) : longint'(mag);
		case (letter_now)
			LET_X: begin
				dx_mm = v;
				job = CMD_MOVE;
			end
			LET_Y: begin
				dy_mm = v;
				job = CMD_MOVE;
			end
			LET_U: job = CMD_PEN_UP;
			LET_D: job = CMD_PEN_DOWN;
			default: ;
		endcase
	endtask

	function automatic longint to_steps(longint d);
		longint s;
		s = d * longint'(steps_per_mm_cfg);
		if (s > STEP_LIMIT)
			s = STEP_LIMIT;
		if (s < -STEP_LIMIT)
			s = -STEP_LIMIT;
		return s;
	endfunction

	task automatic post_work(logic [TASK_W-1:0] kind, longint xd, longint yd, logic last);
		work_item_t w;
		longint xs;
		longint ys;
		longint ax;
		longint ay;
		xs = to_steps(xd);
		ys = to_steps(yd);
		ax = xs < 0 ? -xs : xs;
		ay = ys < 0 ? -ys : ys;
		w.task_res = kind;
		w.x_steps = STEP_W'(xs);
		w.y_steps = STEP_W'(ys);
		w.step_count = COUNT_W'(ax > ay ? ax : ay);
		w.end_of_path = last;
		work_due.push_back(w);
	endtask

	task automatic parse_char(logic [CHAR_W-1:0] c, logic eos);
		if (!arc_skip && !(path_fresh && is_blank(c))) begin
			path_fresh = 1'b0;
			if (c == CH_PIPE) begin
				close_sub();
				post_work(job, dx_mm, dy_mm, eos);
				// a trailing pipe closes the path; the empty token after it is dropped
				if (eos)
					reset_path();
				else
					reset_token();
				return;
			end else if (at_letter) begin
				// first char of a sub-token is its letter, whatever it is, bar a token-opening arc
				if (token_fresh && (c == CH_A_LO || c == CH_A_UP)) begin
					arc_skip = 1'b1;
				end else begin
					case (c)
						CH_X: letter_now = LET_X;
						CH_Y: letter_now = LET_Y;
						CH_U: letter_now = LET_U;
						CH_D: letter_now = LET_D;
						default: letter_now = LET_OTHER;
					endcase
					at_letter = 1'b0;
				end
				token_fresh = 1'b0;
			end else if (c == CH_SPACE) begin
				close_sub();
				open_sub();
			end else if (num_phase == PH_SIGN && is_blank(c)) begin
				// tabs etc. ahead of the sign are skipped
			end else if (num_phase == PH_SIGN && c == CH_PLUS) begin
				num_phase = PH_DIGIT;
			end else if (num_phase == PH_SIGN && c == CH_MINUS) begin
				minus = 1'b1;
				num_phase = PH_DIGIT;
			end else if (num_phase != PH_DONE && c >= CH_0 && c <= CH_9) begin
				mag = mag * 10 + (c - CH_0);
				if (mag > VALUE_CAP)
					mag = VALUE_CAP;
				num_phase = PH_DIGIT;
			end else begin
				num_phase = PH_DONE;
			end
		end
		if (eos) begin
			if (arc_skip) begin
				post_work(CMD_NONE, 0, 0, 1'b1);
			end else begin
				close_sub();
				post_work(job, dx_mm, dy_mm, 1'b1);
			end
			reset_path();
		end
	endtask

	// ---------------------------------------------------------------
	// Character driver: holds a word until taken, then either idles a
	// burst or pops the next one. Prediction runs on acceptance.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : char_driver
		char_word_t w;
		if (!arst_n) begin
			cmd.valid <= 1'b0;
		end else begin
			if (cmd.valid && cmd.ready)
				parse_char(cmd.char_code, cmd.end_of_string);
			if (!cmd.valid || cmd.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd.valid <= 1'b0;
				end else if (char_backlog.size() == 0) begin
					cmd.valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 99) < gap_pct) begin
					gap_left = $urandom_range(0, 7);
					cmd.valid <= 1'b0;
				end else begin
					w = char_backlog.pop_front();
					cmd.char_code <= w.char_code;
					cmd.end_of_string <= w.end_of_string;
					cmd.valid <= 1'b1;
				end
			end
		end
	end

	task automatic report(string what, longint got, longint want);
		$display("%0t ns: %s mismatch: got %0d, want %0d", $time, what, got, want);
		mismatches++;
	endtask

	// ---------------------------------------------------------------
	// Work item monitor: checks each accepted word against the oldest
	// prediction and throttles ready in random bursts.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : work_monitor
		work_item_t w;
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				if (work_due.size() == 0) begin
					report("unexpected work item, task", res.task_res, -1);
				end else begin
					w = work_due.pop_front();
					if (res.task_res !== w.task_res)
						report("task_res", res.task_res, w.task_res);
					if (res.x_steps !== w.x_steps)
						report("x_steps", $signed(res.x_steps), $signed(w.x_steps));
					if (res.y_steps !== w.y_steps)
						report("y_steps", $signed(res.y_steps), $signed(w.y_steps));
					if (res.step_count !== w.step_count)
						report("step_count", res.step_count, w.step_count);
					if (res.end_of_path !== w.end_of_path)
						report("end_of_path", res.end_of_path, w.end_of_path);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				res.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(0, 7);
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	task automatic queue_word(logic [CHAR_W-1:0] c, logic eos);
		char_word_t w;
		w.char_code = c;
		w.end_of_string = eos;
		char_backlog.push_back(w);
		words_queued++;
	endtask

	// one whole path, end_of_string on its last char
	task automatic queue_text(string s);
		for (int i = 0; i < s.len(); i++)
			queue_word(s[i], i == s.len() - 1);
	endtask

	// Mostly well-formed paths with random content; one in ten is pure
	// junk, and some good ones get a byte overwritten.
	task automatic queue_random_path();
		logic [CHAR_W-1:0] p[$];
		int ntok;
		int nsub;
		int ndig;
		logic [CHAR_W-1:0] c;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 12))
				p.push_back(CHAR_W'($urandom_range(0, 255)));
		end else begin
			// leading whitespace to be skipped
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 3))
					p.push_back($urandom_range(0, 1) ? CH_SPACE
						: CHAR_W'($urandom_range(CH_TAB, CH_CR)));
			end
			ntok = $urandom_range(1, 4);
			for (int t = 0; t < ntok; t++) begin
				if (t > 0)
					p.push_back(CH_PIPE);
				case ($urandom_range(0, 19))
					0: ; // empty token
					1: begin
						// arc token: everything after it is dropped
						p.push_back($urandom_range(0, 1) ? CH_A_UP : CH_A_LO);
						repeat ($urandom_range(0, 4))
							p.push_back(CHAR_W'($urandom_range(0, 255)));
					end
					default: begin
						nsub = $urandom_range(1, 3);
						for (int s = 0; s < nsub; s++) begin
							if (s > 0) begin
								p.push_back(CH_SPACE);
								// double space: a space in letter position
								if ($urandom_range(0, 15) == 0)
									p.push_back(CH_SPACE);
							end
							case ($urandom_range(0, 11))
								0, 1, 2: c = CH_X;
								3, 4, 5: c = CH_Y;
								6: c = CH_U;
								7: c = CH_D;
								8: c = CH_X_LO;
								9: c = CH_A_UP;
								10: c = CH_SPACE;
								default: c = CHAR_W'($urandom_range(0, 255));
							endcase
							p.push_back(c);
							if ($urandom_range(0, 7) == 0)
								p.push_back(CH_TAB);
							case ($urandom_range(0, 5))
								0: p.push_back(CH_PLUS);
								1, 2: p.push_back(CH_MINUS);
								default: ;
							endcase
							// long digit runs hit the value clamp
							ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8)
								: $urandom_range(0, 4);
							repeat (ndig)
								p.push_back(CHAR_W'(CH_0 + $urandom_range(0, 9)));
							if ($urandom_range(0, 11) == 0)
								p.push_back(CHAR_W'($urandom_range(0, 255)));
						end
					end
				endcase
			end
			if ($urandom_range(0, 7) == 0)
				p.push_back(CH_PIPE);
			else if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 2))
					p.push_back(CH_SPACE);
			if (p.size() > 0 && $urandom_range(0, 9) == 0)
				p[$urandom_range(0, p.size() - 1)] = CHAR_W'($urandom_range(0, 255));
		end
		if (p.size() == 0)
			p.push_back(CH_PIPE);
		foreach (p[i])
			queue_word(p[i], i == p.size() - 1);
	endtask

	// block idle: nothing queued or in flight, nothing owed, pipe flushed
	task automatic drain();
		while (char_backlog.size() != 0 || cmd.valid || work_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int pick_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 5;
			2: return 25;
			default: return 50;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Main sequence: reset, directed paths at the reset scale, then
	// random phases each with its own scale and idle mix.
	// ---------------------------------------------------------------
	initial begin : stimulus
		logic [SPM_W-1:0] spm;
		int target;
		// all inputs known from time zero
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.char_code = '0;
		cmd.end_of_string = 1'b0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.steps_per_mm = '0;
		gap_left = 0;
		stall_left = 0;
		words_queued = 0;
		mismatches = 0;
		calm = 1'b0;
		gap_pct = 20;
		stall_pct = 20;
		steps_per_mm_cfg = SPM_RESET;
		reset_path();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: leading blank, clamped negative X, plus sign, trailing pipe
		queue_text(" X-99999 Y+7|U|");
		// arc at path start
		queue_text("a");
		// pen down, then arc token dropping the rest
		queue_text("D|A3");
		// tab skipped at start, space in letter position swallows the D
		queue_text("\tX12  D");
		// char code extremes as lone paths
		queue_word(8'h00, 1'b1);
		queue_word(8'hFF, 1'b1);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: spm = 10'd1023;
				1: spm = 10'd1;
				2: spm = 10'd0;
				PHASES - 1: spm = SPM_RESET;
				default: spm = SPM_W'($urandom_range(2, 1022));
			endcase
			cfg.steps_per_mm <= spm;
			cfg.valid <= 1'b1;
			do
				@(posedge clk);
			while (!cfg.ready);
			steps_per_mm_cfg = spm;
			cfg.valid <= 1'b0;

			// last phase runs flat out on both sides
			calm = (ph == PHASES - 1);
			gap_pct = pick_pct();
			stall_pct = pick_pct();
			target = words_queued + PHASE_WORDS;
			while (words_queued < target)
				queue_random_path();
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin : watchdog
		#(12 * 600000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+sv
sv/pmcp_pkg.sv
sv/pmcp_in_if.sv
sv/pmcp_out_if.sv
sv/pmcp_cfg_if.sv
sv/pmcp_parser.sv
sv/pmcp_scale.sv
sv/plotter_move_command_parser.sv
sim/tb.sv
